### rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kinds, keyword table and character classes of the
// source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_COMMENT,
    MODE_STRING,
    MODE_IDENT,
    MODE_ZERO,
    MODE_DEC,
    MODE_DECDOT,
    MODE_HEX
  } mode_e;

  typedef logic [5:0] kind_t;

  localparam kind_t TK_EOF      = 6'd0;
  localparam kind_t TK_ILLEGAL  = 6'd1;
  localparam kind_t TK_IDENT    = 6'd2;
  localparam kind_t TK_INT      = 6'd3;
  localparam kind_t TK_FLOAT    = 6'd4;
  localparam kind_t TK_STRING   = 6'd5;
  localparam kind_t TK_ASSIGN   = 6'd6;
  localparam kind_t TK_PLUS     = 6'd7;
  localparam kind_t TK_MINUS    = 6'd8;
  localparam kind_t TK_STAR     = 6'd9;
  localparam kind_t TK_SLASH    = 6'd10;
  localparam kind_t TK_BANG     = 6'd11;
  localparam kind_t TK_LT       = 6'd12;
  localparam kind_t TK_GT       = 6'd13;
  localparam kind_t TK_EQ       = 6'd14;
  localparam kind_t TK_NE       = 6'd15;
  localparam kind_t TK_LE       = 6'd16;
  localparam kind_t TK_GE       = 6'd17;
  localparam kind_t TK_ARROW    = 6'd18;
  localparam kind_t TK_DEFINE   = 6'd19;
  localparam kind_t TK_PLUS_EQ  = 6'd20;
  localparam kind_t TK_MINUS_EQ = 6'd21;
  localparam kind_t TK_STAR_EQ  = 6'd22;
  localparam kind_t TK_SLASH_EQ = 6'd23;
  localparam kind_t TK_RANGE    = 6'd24;
  localparam kind_t TK_AMP      = 6'd25;
  localparam kind_t TK_COMMA    = 6'd26;
  localparam kind_t TK_SEMI     = 6'd27;
  localparam kind_t TK_COLON    = 6'd28;
  localparam kind_t TK_LPAREN   = 6'd29;
  localparam kind_t TK_RPAREN   = 6'd30;
  localparam kind_t TK_LBRACE   = 6'd31;
  localparam kind_t TK_RBRACE   = 6'd32;
  localparam kind_t TK_LBRACKET = 6'd33;
  localparam kind_t TK_RBRACKET = 6'd34;
  localparam kind_t TK_HASH     = 6'd35;
  localparam kind_t TK_KW_BASE  = 6'd36;

  localparam int NUM_KW = 12;
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd6, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd3
  };
  // text right-aligned: last character in the lowest byte
  localparam logic [63:0] KW_STR [NUM_KW] = '{
    64'("fn"), 64'("if"), 64'("else"), 64'("while"), 64'("return"),
    64'("struct"), 64'("impl"), 64'("asm"), 64'("const"), 64'("protocol"),
    64'("unsafe"), 64'("mut")
  };

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [7:0]  length;
    logic        sat;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic kind_t single_op(input logic [7:0] c);
    kind_t k;
    case (c)
      "=":     k = TK_ASSIGN;
      ":":     k = TK_COLON;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "<":     k = TK_LT;
      ">":     k = TK_GT;
      "!":     k = TK_BANG;
      default: k = TK_ILLEGAL;
    endcase
    return k;
  endfunction

  // zero when the two bytes form no operator
  function automatic kind_t pair_op(input logic [7:0] c, input logic [7:0] b);
    kind_t k;
    k = TK_EOF;
    if (b == "=") begin
      case (c)
        "=":     k = TK_EQ;
        ":":     k = TK_DEFINE;
        "+":     k = TK_PLUS_EQ;
        "-":     k = TK_MINUS_EQ;
        "*":     k = TK_STAR_EQ;
        "/":     k = TK_SLASH_EQ;
        "<":     k = TK_LE;
        ">":     k = TK_GE;
        "!":     k = TK_NE;
        default: k = TK_EOF;
      endcase
    end else if (c == "-" && b == ">") begin
      k = TK_ARROW;
    end else if (c == "." && b == ".") begin
      k = TK_RANGE;
    end
    return k;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
    logic [2:0] pos;
    pos = 3'(KW_LEN[k] - 4'd1) - p;
    return KW_STR[k][pos*8 +: 8];
  endfunction

endpackage

### rtl/stt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_front
// Lexer front end: takes one byte a cycle while the queue is ready, updates
// the token state and hands the one or two tokens of that byte, if any, to the queue as one entry.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int LENGTH_MAX   = 255,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             q_ready_i,
  output logic             in_ready_o,
  output logic             push_o,
  output stt_pkg::entry_t  push_entry_o
);

  localparam int LW = $clog2(LENGTH_MAX + 1);
  localparam int OW = OFFSET_WIDTH;

  stt_pkg::mode_e mode_q, mode_d;
  logic [7:0]     pend_q, pend_d;
  logic [11:0]    kw_q, kw_d;
  logic           flt_q, flt_d;
  logic [LW-1:0]  len_q, len_d;
  logic           ovf_q, ovf_d;
  logic [OW-1:0]  start_q, start_d;
  logic [OW-1:0]  off_q, off_d;

  logic            accept;
  logic [7:0]      b;

  // decode of a byte that opens a token
  stt_pkg::mode_e  st_mode;
  logic            st_emit;
  stt_pkg::kind_t  st_kind;
  logic [LW-1:0]   st_len;
  logic [11:0]     st_kw;

  stt_pkg::kind_t  id_kind;
  stt_pkg::token_t tok [2];
  logic [1:0]      cnt;

  function automatic logic [LW:0] grow(input logic [LW-1:0] l, input logic o);
    logic [LW:0] r;
    if (l >= LW'(LENGTH_MAX)) r = {1'b1, l};
    else r = {o, l + LW'(1)};
    return r;
  endfunction

  function automatic logic [11:0] kw_step(input logic [11:0] cand, input logic [LW-1:0] l,
                                          input logic [7:0] c);
    logic [11:0] r;
    r = cand;
    for (int k = 0; k < stt_pkg::NUM_KW; k++) begin
      if (l >= LW'(stt_pkg::KW_LEN[k]) || stt_pkg::kw_char(4'(k), l[2:0]) != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic stt_pkg::token_t mk(input stt_pkg::kind_t k, input logic [OW-1:0] s,
                                         input logic [LW-1:0] l, input logic o);
    stt_pkg::token_t t;
    t.kind   = k;
    t.start  = 32'(s);
    t.length = 8'(l);
    t.sat    = o;
    return t;
  endfunction

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign b          = in_byte_i;

  always_comb begin
    id_kind = stt_pkg::TK_IDENT;
    if (!ovf_q) begin
      for (int k = stt_pkg::NUM_KW - 1; k >= 0; k--) begin
        if (kw_q[k] && len_q == LW'(stt_pkg::KW_LEN[k])) begin
          id_kind = stt_pkg::TK_KW_BASE + 6'(k);
        end
      end
    end
  end

  always_comb begin
    st_mode = stt_pkg::MODE_IDLE;
    st_emit = 1'b0;
    st_kind = stt_pkg::TK_ILLEGAL;
    st_len  = '0;
    st_kw   = '1;
    if (!stt_pkg::is_space(b)) begin
      case (b)
        "\"": st_mode = stt_pkg::MODE_STRING;
        "=", ":", "+", "-", "*", "/", "<", ">", "!", ".": st_mode = stt_pkg::MODE_OP;
        "(": begin st_emit = 1'b1; st_kind = stt_pkg::TK_LPAREN;   end
        ")": begin st_emit = 1'b1; st_kind = stt_pkg::TK_RPAREN;   end
        "{": begin st_emit = 1'b1; st_kind = stt_pkg::TK_LBRACE;   end
        "}": begin st_emit = 1'b1; st_kind = stt_pkg::TK_RBRACE;   end
        "[": begin st_emit = 1'b1; st_kind = stt_pkg::TK_LBRACKET; end
        "]": begin st_emit = 1'b1; st_kind = stt_pkg::TK_RBRACKET; end
        "#": begin st_emit = 1'b1; st_kind = stt_pkg::TK_HASH;     end
        "&": begin st_emit = 1'b1; st_kind = stt_pkg::TK_AMP;      end
        ",": begin st_emit = 1'b1; st_kind = stt_pkg::TK_COMMA;    end
        ";": begin st_emit = 1'b1; st_kind = stt_pkg::TK_SEMI;     end
        default: begin
          if (stt_pkg::is_alpha(b) || b == "_") begin
            st_mode = stt_pkg::MODE_IDENT;
            st_len  = LW'(1);
            st_kw   = kw_step('1, '0, b);
          end else if (b == "0") begin
            st_mode = stt_pkg::MODE_ZERO;
            st_len  = LW'(1);
          end else if (stt_pkg::is_digit(b)) begin
            st_mode = stt_pkg::MODE_DEC;
            st_len  = LW'(1);
          end else begin
            st_emit = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    logic          do_clear;
    logic          do_start;
    logic [LW:0]   g;
    logic [LW-1:0] dl;
    logic          dov;
    logic          dflt;
    stt_pkg::kind_t pk;

    mode_d  = mode_q;
    pend_d  = pend_q;
    kw_d    = kw_q;
    flt_d   = flt_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    start_d = start_q;
    off_d   = off_q;
    tok[0]  = '0;
    tok[1]  = '0;
    cnt     = 2'd0;
    do_clear = 1'b0;
    do_start = 1'b0;
    g    = grow(len_q, ovf_q);
    dl   = len_q;
    dov  = ovf_q;
    dflt = flt_q;
    pk   = stt_pkg::pair_op(pend_q, b);

    if (b == 8'd0) begin
      case (mode_q)
        stt_pkg::MODE_OP: begin
          tok[cnt[0]] = mk(stt_pkg::single_op(pend_q), start_q, LW'(1), 1'b0);
          cnt = cnt + 2'd1;
        end
        stt_pkg::MODE_STRING: begin
          tok[cnt[0]] = mk(stt_pkg::TK_ILLEGAL, start_q, len_q, ovf_q);
          cnt = cnt + 2'd1;
        end
        stt_pkg::MODE_IDENT: begin
          tok[cnt[0]] = mk(id_kind, start_q, len_q, ovf_q);
          cnt = cnt + 2'd1;
        end
        stt_pkg::MODE_ZERO, stt_pkg::MODE_DEC, stt_pkg::MODE_HEX: begin
          tok[cnt[0]] = mk(flt_q ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT, start_q, len_q, ovf_q);
          cnt = cnt + 2'd1;
        end
        stt_pkg::MODE_DECDOT: begin
          tok[cnt[0]] = mk(stt_pkg::TK_FLOAT, start_q, g[LW-1:0], g[LW]);
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      tok[cnt[0]] = mk(stt_pkg::TK_EOF, off_q, '0, 1'b0);
      cnt = cnt + 2'd1;
      do_clear = 1'b1;
      start_d  = '0;
      off_d    = '0;
    end else begin
      off_d = off_q + OW'(1);
      case (mode_q)
        stt_pkg::MODE_OP: begin
          if (pend_q == "/" && b == "/") begin
            do_clear = 1'b1;
          end else if (pk != stt_pkg::TK_EOF) begin
            tok[cnt[0]] = mk(pk, start_q, LW'(2), 1'b0);
            cnt = cnt + 2'd1;
            do_clear = 1'b1;
          end else begin
            tok[cnt[0]] = mk(stt_pkg::single_op(pend_q), start_q, LW'(1), 1'b0);
            cnt = cnt + 2'd1;
            do_start = 1'b1;
          end
        end
        stt_pkg::MODE_COMMENT: begin
          if (b == 8'h0a) do_clear = 1'b1;
        end
        stt_pkg::MODE_STRING: begin
          if (b == "\"") begin
            tok[cnt[0]] = mk(stt_pkg::TK_STRING, start_q, len_q, ovf_q);
            cnt = cnt + 2'd1;
            do_clear = 1'b1;
          end else begin
            {ovf_d, len_d} = g;
          end
        end
        stt_pkg::MODE_IDENT: begin
          if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b) || b == "_") begin
            kw_d = kw_step(kw_q, len_q, b);
            {ovf_d, len_d} = g;
          end else begin
            tok[cnt[0]] = mk(id_kind, start_q, len_q, ovf_q);
            cnt = cnt + 2'd1;
            do_start = 1'b1;
          end
        end
        stt_pkg::MODE_ZERO, stt_pkg::MODE_DEC, stt_pkg::MODE_DECDOT: begin
          if (mode_q == stt_pkg::MODE_ZERO && (b == "x" || b == "X")) begin
            mode_d = stt_pkg::MODE_HEX;
            {ovf_d, len_d} = g;
          end else if (mode_q == stt_pkg::MODE_DECDOT && b == ".") begin
            // number ends before the two dots, which give a range
            tok[cnt[0]] = mk(flt_q ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT, start_q, len_q, ovf_q);
            cnt = cnt + 2'd1;
            tok[cnt[0]] = mk(stt_pkg::TK_RANGE, off_q - OW'(1), LW'(2), 1'b0);
            cnt = cnt + 2'd1;
            do_clear = 1'b1;
          end else begin
            if (mode_q == stt_pkg::MODE_DECDOT) begin
              // the dot joins the number
              dl    = g[LW-1:0];
              dov   = g[LW];
              dflt  = 1'b1;
              flt_d = 1'b1;
              len_d = dl;
              ovf_d = dov;
            end
            if (stt_pkg::is_digit(b)) begin
              mode_d = stt_pkg::MODE_DEC;
              {ovf_d, len_d} = grow(dl, dov);
            end else if (b == ".") begin
              mode_d = stt_pkg::MODE_DECDOT;
            end else begin
              tok[cnt[0]] = mk(dflt ? stt_pkg::TK_FLOAT : stt_pkg::TK_INT, start_q, dl, dov);
              cnt = cnt + 2'd1;
              do_start = 1'b1;
            end
          end
        end
        stt_pkg::MODE_HEX: begin
          if (stt_pkg::is_hex(b)) begin
            {ovf_d, len_d} = g;
          end else begin
            tok[cnt[0]] = mk(stt_pkg::TK_INT, start_q, len_q, ovf_q);
            cnt = cnt + 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    if (do_clear || do_start) begin
      mode_d = (mode_q == stt_pkg::MODE_OP && pend_q == "/" && b == "/")
             ? stt_pkg::MODE_COMMENT : stt_pkg::MODE_IDLE;
      pend_d = '0;
      kw_d   = '1;
      flt_d  = 1'b0;
      len_d  = '0;
      ovf_d  = 1'b0;
    end
    if (do_start) begin
      mode_d  = st_mode;
      pend_d  = b;
      kw_d    = st_kw;
      len_d   = st_len;
      start_d = off_q;
      if (st_emit) begin
        tok[cnt[0]] = mk(st_kind, off_q, LW'(1), 1'b0);
        cnt = cnt + 2'd1;
      end
    end
  end

  assign push_o             = accept && (cnt != 2'd0);
  assign push_entry_o.two   = cnt[1];
  assign push_entry_o.tok0  = tok[0];
  assign push_entry_o.tok1  = tok[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      pend_q  <= '0;
      kw_q    <= '1;
      flt_q   <= 1'b0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      start_q <= '0;
      off_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      kw_q    <= kw_d;
      flt_q   <= flt_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      start_q <= start_d;
      off_q   <= off_d;
    end
  end

endmodule

### rtl/stt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of token entries between the lexer front end and the output
// stage.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::entry_t push_entry_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            nonempty_o,
  output stt_pkg::entry_t pop_entry_o
);

  stt_pkg::entry_t mem_q [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [stt_pkg::QPTR_W:0]   count_q;

  assign ready_o     = count_q != (stt_pkg::QPTR_W+1)'(stt_pkg::QUEUE_DEPTH);
  assign nonempty_o  = count_q != '0;
  assign pop_entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

### rtl/stt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_back
// Output stage: holds one queue entry in a register and sends its tokens
// one beat at a time.
// ----------------------------------------------------------------------------
module stt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            nonempty_i,
  input  stt_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [47:0]     out_data_o,
  output logic            out_last_o
);

  stt_pkg::entry_t cur_q;
  logic            valid_q;
  logic            idx_q;
  logic            last_beat;
  logic            done;
  stt_pkg::token_t tok;

  assign last_beat   = !cur_q.two || idx_q;
  assign done        = valid_q && out_ready_i && last_beat;
  assign pop_o       = nonempty_i && (!valid_q || done);
  assign tok         = idx_q ? cur_q.tok1 : cur_q.tok0;
  assign out_valid_o = valid_q;
  assign out_last_o  = last_beat;
  assign out_data_o  = {1'b0, tok.sat, tok.length, tok.start, tok.kind};

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (valid_q && out_ready_i) begin
      idx_q <= 1'b1;
    end
  end

endmodule

### rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens of kind, start and length out.
// ----------------------------------------------------------------------------
// one byte accepted per cycle while the queue has room; a byte yields zero,
// one or two tokens; tokens leave one beat each, at one per cycle from the
// output register while m_axis_tready is high; a four-entry queue absorbs
// bursts
// reset is asynchronous and clears the lexer state, offsets and the queue
module source_text_tokenizer #(
  parameter int LENGTH_MAX   = 255,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] token_kind, [37:6] token_start, [45:38] token_length,
  // [46] length_saturated, [47] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_in_run
);

  logic            q_ready;
  logic            push;
  stt_pkg::entry_t push_entry;
  logic            pop;
  logic            nonempty;
  stt_pkg::entry_t pop_entry;

  stt_front #(
    .LENGTH_MAX   (LENGTH_MAX),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .q_ready_i    (q_ready),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  stt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .nonempty_o   (nonempty),
    .pop_entry_o  (pop_entry)
  );

  stt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
